// ===== hw/rtl/sma_pkg.sv =====
// ============================================================================
// sma_pkg - shared constants for the moving average block
// Register map, field widths and reset values of the configuration port.
// ============================================================================
package sma_pkg;

    // configuration bus
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // previous_count register
    localparam int            CFG_W          = 10;
    localparam logic [9:0]    PREV_COUNT_RST = 10'd1000;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_PREVIOUS_COUNT = 1'b0
    } t_reg_index;

endpackage

// ===== hw/rtl/sma_in_if.sv =====
// ============================================================================
// sma_in_if - sample channel
// Valid/ready channel carrying one sample and its series-end flag.
// ============================================================================
interface sma_in_if #(
    parameter int SAMPLE_BITS = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          series_end;

    modport source (output valid, output sample, output series_end, input ready);
    modport sink   (input valid, input sample, input series_end, output ready);
endinterface

// ===== hw/rtl/sma_out_if.sv =====
// ============================================================================
// sma_out_if - average channel
// Valid/ready channel carrying one mean and the number of samples behind it.
// ============================================================================
interface sma_out_if #(
    parameter int SAMPLE_BITS = 32,
    parameter int USED_BITS   = 11
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic        [USED_BITS-1:0]   window_used;

    modport source (output valid, output average, output window_used, input ready);
    modport sink   (input valid, input average, input window_used, output ready);
endinterface

// ===== hw/rtl/sma_ram.sv =====
// ============================================================================
// sma_ram - generic simple dual-port ram
// One write port, one read port, registered read data.
// ============================================================================
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sma_div.sv =====
// ============================================================================
// sma_div - bit-serial signed divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ============================================================================
module sma_div #(
    parameter int DIVIDEND_W = 42,
    parameter int DIVISOR_W  = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic signed [DIVIDEND_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    always_comb begin
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
        if (i_start) begin
            n_cnt = CW'(DIVIDEND_W);
            n_neg = i_dividend[DIVIDEND_W-1];
            n_quo = i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_rem = fits ? DIVISOR_W'(shifted - {1'b0, r_dvs}) : shifted[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

// ===== hw/rtl/simple_moving_average.sv =====
// ============================================================================
// simple_moving_average - windowed mean of a signed sample stream
// Keeps a sample ring and a running window sum, adjusts the window one ring
// entry at a time and divides the sum by the window size bit-serially.
// ============================================================================
//
//  channel        | dir | fields                              | handshake
//  ---------------+-----+-------------------------------------+-----------
//  i_sample_if    | in  | sample, series_end                  | valid/ready
//  o_average_if   | out | average, window_used                | valid/ready
//  apb (psel ...) | in  | previous_count at byte address 0    | psel/penable
//
//  sequence per item: S_IDLE, then S_STEP and S_ACC for each ring entry added
//    to or dropped from the window, a last S_STEP, then the serial divider in S_DIV;
//    one entry is dropped in the steady state, up to MAX_WINDOW after a previous_count change
//  reset: synchronous, active low; the ring needs no clearing pass
//  stalls: a finished mean waits in the output register while the next sample
//    is taken; the divider result holds until that register frees
//
module simple_moving_average #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sma_in_if.sink                       i_sample_if,
    sma_out_if.source                    o_average_if,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sma_pkg::APB_AW-1:0]   paddr,
    input  logic [sma_pkg::APB_DW-1:0]   pwdata,
    output logic [sma_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    // ring address, window count and sum widths
    localparam int AW        = $clog2(MAX_WINDOW);
    localparam int USED_BITS = $clog2(MAX_WINDOW) + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CMP_W     = (USED_BITS > sma_pkg::CFG_W) ? USED_BITS : sma_pkg::CFG_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_ACC,
        S_DIV
    } t_state;

    t_state                        r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_cur, n_cur;        // sample in work
    logic                          r_last, n_last;      // its series-end flag
    logic [USED_BITS-1:0]          r_tgt, n_tgt;        // preceding samples wanted
    logic [USED_BITS-1:0]          r_m, n_m;            // samples now in r_acc
    logic [AW-1:0]                 r_old, n_old;        // oldest slot in r_acc
    logic [AW-1:0]                 r_wp, n_wp;          // next slot to write
    logic [USED_BITS-1:0]          r_fill, n_fill;      // prior samples in series
    logic signed [SUM_BITS-1:0]    r_acc, n_acc;        // running window sum
    logic                          r_sub, n_sub;        // pending ring read drops
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_avg, n_avg;
    logic [USED_BITS-1:0]          r_used, n_used;
    logic [sma_pkg::CFG_W-1:0]     r_prev, n_prev;      // previous_count

    // ring and divider hookup
    logic                          ram_we;
    logic [AW-1:0]                 ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SUM_BITS-1:0]    ring_ext;
    logic signed [SUM_BITS-1:0]    cur_ext;
    logic signed [SUM_BITS-1:0]    sum_fin;
    logic                          div_start;
    logic                          div_busy;
    logic signed [SUM_BITS-1:0]    div_quo;

    // window limit terms
    logic [CMP_W-1:0]              prev_x, fill_x, cap_x, k_x;
    logic                          cfg_wr;

    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_cur),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sma_div #(
        .DIVIDEND_W (SUM_BITS),
        .DIVISOR_W  (USED_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_fin),
        .i_divisor  (r_tgt + 1'b1),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    assign ring_ext = {{(SUM_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
    assign cur_ext  = {{(SUM_BITS-SAMPLE_BITS){r_cur[SAMPLE_BITS-1]}}, r_cur};
    assign sum_fin  = r_acc + cur_ext;

    // preceding samples used: min of register, fill and ring depth less one
    always_comb begin
        prev_x = CMP_W'(r_prev);
        fill_x = CMP_W'(r_fill);
        cap_x  = CMP_W'(MAX_WINDOW - 1);
        k_x    = prev_x;
        if (fill_x < k_x) begin
            k_x = fill_x;
        end
        if (cap_x < k_x) begin
            k_x = cap_x;
        end
    end

    // register write; every address with paddr[2] clear maps to previous_count
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == sma_pkg::REG_PREVIOUS_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sma_pkg::REG_PREVIOUS_COUNT) ?
                    {{(sma_pkg::APB_DW-sma_pkg::CFG_W){1'b0}}, r_prev} : '0;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_last      = r_last;
        n_tgt       = r_tgt;
        n_m         = r_m;
        n_old       = r_old;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_acc       = r_acc;
        n_sub       = r_sub;
        n_out_valid = r_out_valid;
        n_avg       = r_avg;
        n_used      = r_used;
        n_prev      = cfg_wr ? pwdata[sma_pkg::CFG_W-1:0] : r_prev;
        ram_we      = 1'b0;
        ram_raddr   = r_old;
        div_start   = 1'b0;

        // output transaction completes
        if (r_out_valid && o_average_if.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_sample_if.valid) begin
                    n_cur   = i_sample_if.sample;
                    n_last  = i_sample_if.series_end;
                    n_tgt   = USED_BITS'(k_x);
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_m > r_tgt) begin
                    // drop the oldest sample of the window
                    ram_raddr = r_old;
                    n_old     = (r_old == LAST_SLOT) ? '0 : r_old + 1'b1;
                    n_m       = r_m - 1'b1;
                    n_sub     = 1'b1;
                    n_state   = S_ACC;
                end else if (r_m < r_tgt) begin
                    // pull in the next older sample
                    ram_raddr = (r_old == '0) ? LAST_SLOT : r_old - 1'b1;
                    n_old     = ram_raddr;
                    n_m       = r_m + 1'b1;
                    n_sub     = 1'b0;
                    n_state   = S_ACC;
                end else begin
                    // window settled: add current sample, store it, divide
                    ram_we    = 1'b1;
                    div_start = 1'b1;
                    n_acc     = sum_fin;
                    n_m       = r_tgt + 1'b1;
                    n_wp      = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
                    if (r_fill < USED_BITS'(MAX_WINDOW)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (r_last) begin
                        // series end clears the history
                        n_acc  = '0;
                        n_m    = '0;
                        n_wp   = '0;
                        n_old  = '0;
                        n_fill = '0;
                    end
                    n_state   = S_DIV;
                end
            end
            S_ACC: begin
                n_acc   = r_sub ? (r_acc - ring_ext) : (r_acc + ring_ext);
                n_state = S_STEP;
            end
            S_DIV: begin
                if (!div_busy && (!r_out_valid || o_average_if.ready)) begin
                    n_out_valid = 1'b1;
                    n_avg       = div_quo[SAMPLE_BITS-1:0];
                    n_used      = r_tgt + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= '0;
            r_old       <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_prev      <= sma_pkg::PREV_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_m         <= n_m;
            r_old       <= n_old;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
        end
        r_cur  <= n_cur;
        r_last <= n_last;
        r_tgt  <= n_tgt;
        r_sub  <= n_sub;
        r_avg  <= n_avg;
        r_used <= n_used;
    end

    assign i_sample_if.ready        = (r_state == S_IDLE);
    assign o_average_if.valid       = r_out_valid;
    assign o_average_if.average     = r_avg;
    assign o_average_if.window_used = r_used;

    // window in the running sum never reaches past the samples of the series
    a_window_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m <= r_fill)
        else $error("running window larger than fill count");

    // target window stays within fill and ring depth while adjusting
    a_target_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_tgt <= r_fill && r_tgt < USED_BITS'(MAX_WINDOW)))
        else $error("window target out of range");

    // no sample taken while the divider works
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !i_sample_if.ready)
        else $error("sample accepted during division");

    // a finished division lands in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !div_busy && (!r_out_valid || o_average_if.ready))
        |=> (r_out_valid && r_state == S_IDLE))
        else $error("division result not loaded");

endmodule

// ===== bench/tb_simple_moving_average.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_simple_moving_average - self-checking bench for the moving average block
// A directed table covers the field extremes, truncation toward zero, single
// sample series and window changes in the middle of a series. Random series
// follow under several previous_count settings. Each mean is checked against a
// local ring model or a typed table value, with bursty input and a stalling output.
// ============================================================================
module tb_simple_moving_average;

    localparam int CFG_W    = sma_pkg::CFG_W;
    localparam int APB_AW   = sma_pkg::APB_AW;
    localparam int APB_DW   = sma_pkg::APB_DW;

    localparam int SAMPLE_W = 32;
    localparam int USED_W   = 11;
    localparam int MAX_WIN  = 1024;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'h8000_0000;

    // output ready patterns, picked anew at random by the output checker
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_LONG
    } t_rx_mode;

    // one expected mean
    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic        [USED_W-1:0]   window_used;
    } t_mean;

    // one row of the directed table: optional register write, then a sample
    typedef struct packed {
        logic                       set_cfg;
        logic [CFG_W-1:0]           cfg;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       series_end;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want_avg;
        logic [USED_W-1:0]          want_used;
    } t_dir_row;

    localparam int DIR_N = 25;

    // typed rows are the ones whose mean is obvious: a first sample or a window of one,
    // equal samples, a truncation toward zero; the rest go through the predictor
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{1'b0, 10'd0,    32'sd100, 1'b0, 1'b1, 32'sd100, 11'd1},
        '{1'b0, 10'd0,    32'sd7,   1'b1, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    S_MAX,    1'b0, 1'b1, S_MAX,    11'd1},
        '{1'b0, 10'd0,    S_MAX,    1'b0, 1'b1, S_MAX,    11'd2},
        '{1'b0, 10'd0,    S_MAX,    1'b1, 1'b1, S_MAX,    11'd3},
        '{1'b0, 10'd0,    S_MIN,    1'b0, 1'b1, S_MIN,    11'd1},
        '{1'b0, 10'd0,    S_MIN,    1'b0, 1'b1, S_MIN,    11'd2},
        '{1'b0, 10'd0,    S_MIN,    1'b1, 1'b1, S_MIN,    11'd3},
        '{1'b0, 10'd0,    -32'sd7,  1'b0, 1'b1, -32'sd7,  11'd1},
        // -5 / 2 rounds toward zero
        '{1'b0, 10'd0,    32'sd2,   1'b1, 1'b1, -32'sd2,  11'd2},
        '{1'b0, 10'd0,    -32'sd1,  1'b0, 1'b1, -32'sd1,  11'd1},
        // -1 / 2 rounds to zero, not to -1
        '{1'b0, 10'd0,    32'sd0,   1'b1, 1'b1, 32'sd0,   11'd2},
        // single sample series
        '{1'b0, 10'd0,    32'sd42,  1'b1, 1'b1, 32'sd42,  11'd1},
        '{1'b0, 10'd0,    32'sd0,   1'b0, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    S_MAX,    1'b0, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    S_MIN,    1'b0, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    -32'sd1,  1'b0, 1'b0, 32'sd0,   11'd0},
        // window shrinks to the current sample alone in mid-series
        '{1'b1, 10'd0,    32'sd5,   1'b0, 1'b1, 32'sd5,   11'd1},
        '{1'b0, 10'd0,    S_MIN,    1'b0, 1'b1, S_MIN,    11'd1},
        '{1'b1, 10'd1,    32'sd9,   1'b0, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    32'sd3,   1'b0, 1'b0, 32'sd0,   11'd0},
        // window grows back over the ring in mid-series
        '{1'b1, 10'd1023, 32'sd1,   1'b0, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    S_MAX,    1'b1, 1'b0, 32'sd0,   11'd0},
        '{1'b0, 10'd0,    -32'sd42, 1'b1, 1'b1, -32'sd42, 11'd1},
        '{1'b1, 10'd1000, 32'sd11,  1'b1, 1'b1, 32'sd11,  11'd1}
    };

    // clock, reset and configuration port
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    sma_in_if  #(.SAMPLE_BITS(SAMPLE_W))                     smp_if ();
    sma_out_if #(.SAMPLE_BITS(SAMPLE_W), .USED_BITS(USED_W)) avg_if ();

    simple_moving_average #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_if  (smp_if.sink),
        .o_average_if (avg_if.source),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 i_clk = ~i_clk;

    // local copy of the block state: sample ring, fill count, write slot
    logic signed [SAMPLE_W-1:0] hist_ring [MAX_WIN];
    logic [USED_W-1:0]          hist_fill;
    logic [9:0]                 hist_wptr;
    logic [CFG_W-1:0]           cfg_prev;

    // means still owed by the block, oldest first
    t_mean pending_means [$];
    int    fail_count = 0;

    // sender state across calls
    int    burst_left  = 0;
    int    series_left = 0;
    bit    bursty      = 1'b1;

    // receiver stall pattern
    t_rx_mode    rx_mode  = RX_STEADY;
    int          rx_hold  = 0;
    int unsigned rx_cycle = 0;

    // windowed mean of one sample, then the ring and the counters move on
    function automatic void predict_mean(input logic signed [SAMPLE_W-1:0] value,
                                         input logic last,
                                         output logic signed [SAMPLE_W-1:0] avg,
                                         output logic [USED_W-1:0] used);
        int unsigned     prior;
        int unsigned     k;
        longint signed   total;
        longint signed   cnt;
        prior = cfg_prev;
        if (prior > hist_fill)
            prior = hist_fill;
        if (prior > MAX_WIN - 1)
            prior = MAX_WIN - 1;
        total = value;
        for (k = 1; k <= prior; k++)
            total += hist_ring[10'(hist_wptr - k)];
        cnt  = longint'(prior) + 1;
        // signed division truncates toward zero, as the block does
        avg  = SAMPLE_W'(total / cnt);
        used = USED_W'(cnt);
        hist_ring[hist_wptr] = value;
        hist_wptr = hist_wptr + 10'd1;
        if (hist_fill < MAX_WIN)
            hist_fill = hist_fill + 1'b1;
        // series end: history forgotten after this mean
        if (last) begin
            hist_fill = '0;
            hist_wptr = '0;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return $signed(SAMPLE_W'($urandom_range(0, 2))) - 32'sd1;
            3, 4, 5: return $signed(SAMPLE_W'($urandom_range(0, 2000))) - 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    // mostly short series, some long enough to fill a big window
    function automatic int pick_series_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 8);
        else if (r < 85)
            return $urandom_range(9, 60);
        else
            return $urandom_range(61, 300);
    endfunction

    // present one sample and hold it until the transaction completes
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic last,
                               input bit typed, input logic signed [SAMPLE_W-1:0] want_avg,
                               input logic [USED_W-1:0] want_used);
        t_mean m;
        smp_if.valid      <= 1'b1;
        smp_if.sample     <= value;
        smp_if.series_end <= last;
        do @(posedge i_clk); while (!(smp_if.valid === 1'b1 && smp_if.ready === 1'b1));
        // the predictor runs on every sample, typed rows only replace its answer
        predict_mean(value, last, m.average, m.window_used);
        if (typed) begin
            m.average     = want_avg;
            m.window_used = want_used;
        end
        pending_means.push_back(m);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            smp_if.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending until every owed mean has come out
    task automatic wait_for_means();
        smp_if.valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
    endtask

    // apb write of previous_count, then a read back of the same register
    task automatic write_previous_count(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(sma_pkg::REG_PREVIOUS_COUNT));
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        cfg_prev = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[CFG_W-1:0] !== value) begin
            $display("%0t ns: previous_count read back expected %0d actual %0d",
                     $time, value, prdata[CFG_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random samples in series, in bursts when the sender is bursty
    task automatic send_stream(input int count);
        int k;
        logic last;
        for (k = 0; k < count; k++) begin
            if (bursty) begin
                if (burst_left == 0) begin
                    hold_off(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
            end
            if (series_left == 0)
                series_left = pick_series_len();
            last = (series_left == 1);
            series_left--;
            push_sample(pick_sample(), last, 1'b0, '0, '0);
        end
    endtask

    // output side: check each transaction, then pick the next ready value
    always @(posedge i_clk) begin : avg_check
        t_mean want;
        if (i_rst_n && avg_if.valid === 1'b1 && avg_if.ready === 1'b1) begin
            if (pending_means.size() == 0) begin
                $display("%0t ns: mean with none expected, average %0d window_used %0d",
                         $time, avg_if.average, avg_if.window_used);
                fail_count++;
            end else begin
                want = pending_means.pop_front();
                if (avg_if.average !== want.average) begin
                    $display("%0t ns: average expected %0d actual %0d",
                             $time, want.average, avg_if.average);
                    fail_count++;
                end
                if (avg_if.window_used !== want.window_used) begin
                    $display("%0t ns: window_used expected %0d actual %0d",
                             $time, want.window_used, avg_if.window_used);
                    fail_count++;
                end
            end
        end

        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_STEADY: avg_if.ready <= 1'b1;
            RX_COIN:   avg_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: avg_if.ready <= (rx_cycle[1:0] == 2'd0);
            RX_LONG: begin
                // alternate stretches of stall and flow of random length
                if (rx_hold == 0) begin
                    avg_if.ready <= ~avg_if.ready;
                    rx_hold      <= $urandom_range(1, 60);
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
            default: avg_if.ready <= 1'b1;
        endcase
    end

    // main sequence
    initial begin : stimulus
        int       r;
        int       ph;
        t_dir_row row;

        smp_if.valid      = 1'b0;
        smp_if.sample     = '0;
        smp_if.series_end = 1'b0;
        avg_if.ready      = 1'b0;

        // predictor starts from the reset state
        for (r = 0; r < MAX_WIN; r++)
            hist_ring[r] = '0;
        hist_fill = '0;
        hist_wptr = '0;
        cfg_prev  = sma_pkg::PREV_COUNT_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, register writes only with nothing in flight
        for (r = 0; r < DIR_N; r++) begin
            row = DIR_ROWS[r];
            if (row.set_cfg) begin
                wait_for_means();
                write_previous_count(row.cfg);
            end
            push_sample(row.sample, row.series_end, row.typed, row.want_avg, row.want_used);
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 4));
        end

        // random phases; a series may run on across a register change
        for (ph = 0; ph < 8; ph++) begin
            wait_for_means();
            case (ph)
                0: write_previous_count(10'd1023);
                1: write_previous_count(10'd0);
                2: write_previous_count(10'd1000);
                3: write_previous_count(10'd1);
                4: write_previous_count(CFG_W'($urandom_range(3, 40)));
                5: write_previous_count(10'd2);
                6: write_previous_count(CFG_W'($urandom_range(0, 1023)));
                default: write_previous_count(CFG_W'($urandom_range(41, 999)));
            endcase
            bursty = (ph % 3 != 1);
            if (ph == 0) begin
                // one long series: ring wraps, fill saturates, window capped,
                // and it carries on through the next two register changes
                series_left = 1300;
                send_stream(1100);
            end else if (ph == 4) begin
                send_stream(57);
                wait_for_means();
                send_stream(58);
            end else begin
                send_stream(115);
            end
        end

        wait_for_means();
        // anything that still comes out now is flagged by the checker
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
